### rtl/diag_request_responder_defines.svh
// Assertion helpers for the diagnostic responder checkers.
`ifndef DIAG_REQUEST_RESPONDER_DEFINES_SVH
`define DIAG_REQUEST_RESPONDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DREQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dreq check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define DREQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dreq check failed");

`endif

### rtl/dreq_pkg.sv
package dreq_pkg;

  localparam int IN_W  = 168;
  localparam int OUT_W = 56;
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 15;
  localparam int KEY_BYTES = 4;

  // services
  localparam logic [7:0] SID_SHOW = 8'h01;
  localparam logic [7:0] SID_SEC  = 8'h27;
  localparam logic [7:0] SID_DL   = 8'h34;
  localparam logic [7:0] RSP_OFS  = 8'h40;
  localparam logic [7:0] RSP_NEG  = 8'h7F;
  localparam logic [7:0] NRC_BAD_KEY = 8'h35;
  localparam logic [7:0] DL_FMT   = 8'h44;
  localparam logic [7:0] DL_LEN_FMT = 8'h20;
  localparam logic [7:0] SEC_SEED = 8'h03;
  localparam logic [7:0] SEC_KEY  = 8'h04;

  // PIDs
  localparam logic [7:0] PID_SUP00 = 8'h00;
  localparam logic [7:0] PID_MON   = 8'h01;
  localparam logic [7:0] PID_LOAD  = 8'h04;
  localparam logic [7:0] PID_TEMP  = 8'h05;
  localparam logic [7:0] PID_RPM   = 8'h0C;
  localparam logic [7:0] PID_THR   = 8'h11;
  localparam logic [7:0] PID_STD   = 8'h1C;
  localparam logic [7:0] PID_RUN   = 8'h1F;
  localparam logic [7:0] PID_SUP20 = 8'h20;
  localparam logic [7:0] PID_DIST  = 8'h21;
  localparam logic [7:0] PID_FUEL  = 8'h2F;
  localparam logic [7:0] PID_SUP40 = 8'h40;
  localparam logic [7:0] PID_FTYPE = 8'h51;
  localparam logic [7:0] PID_SUP60 = 8'h60;
  localparam logic [7:0] PID_TREQ  = 8'h61;
  localparam logic [7:0] PID_TACT  = 8'h62;
  localparam logic [7:0] PID_TREF  = 8'h63;

  localparam logic REG_KEY_MUL = 1'b0;
  localparam logic REG_KEY_XOR = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] seed;
    logic [31:0] mult;
    logic [31:0] mask;
    logic [31:0] resp;
  } key_req_t;

  typedef struct packed {
    logic done;
    logic ok;
  } key_rsp_t;

  // 255 * a
  function automatic logic [DIV_NW-1:0] mul255(input logic [15:0] a);
    return {a, 8'h00} - {8'h00, a};
  endfunction

  // 100 * a = 64a + 32a + 4a
  function automatic logic [DIV_NW-1:0] mul100(input logic [15:0] a);
    return {2'b00, a, 6'b0} + {3'b000, a, 5'b0} + {6'b0, a, 2'b00};
  endfunction

endpackage

### rtl/diag_request_responder.sv
// Diagnostic request responder. One request transaction in, at most one reply
// transaction out (requests that get no reply produce nothing on m_*). Only
// one request is worked on at a time: s_tready is high only while the block
// is idle and out of reset, but a finished reply may still sit in the output
// register while the next request is taken. The key check compares four key
// bytes, one per cycle; the load, temperature, torque and throttle PIDs go
// through the bit-serial divider (24 quotient bits, one per cycle; throttle
// needs two passes). A zero available torque forces the torque byte to zero
// instead of the quotient. Key registers must be written via
// cfg_we/cfg_index/cfg_wdata while idle: that binds the user, as the block
// itself does not enforce it. Reset clears them and locks the block.
module diag_request_responder
  import dreq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // request: service_id, param_byte, payload_word, random_word,
  // torque_actual, torque_requested, torque_available, system_temp,
  // motor_speed, throttle_level (lowest bits first)
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  // reply: reply_length, reply_byte0 .. reply_byte5, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_DIV2 = 5'b00100,
    S_KEY  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  // config and security state
  logic [31:0] key_mul;
  logic [31:0] key_xor;
  logic        unlocked;
  logic        seed_fresh;
  logic [31:0] seed_value;

  // request fields off the bus
  logic [7:0]  in_sid, in_prm;
  logic [31:0] in_pay, in_rnd;
  logic [15:0] in_tact, in_treq, in_temp;
  logic [14:0] in_tav;
  logic [13:0] in_speed;
  logic [10:0] in_thr;

  assign in_sid   = s_tdata[7:0];
  assign in_prm   = s_tdata[15:8];
  assign in_pay   = s_tdata[47:16];
  assign in_rnd   = s_tdata[79:48];
  assign in_tact  = s_tdata[95:80];
  assign in_treq  = s_tdata[111:96];
  assign in_tav   = s_tdata[126:112];
  assign in_temp  = s_tdata[142:127];
  assign in_speed = s_tdata[156:143];
  assign in_thr   = s_tdata[167:157];

  // latched request
  logic [7:0]  sid_q, prm_q;
  logic [31:0] pay_q, rnd_q;
  logic [14:0] tav_q;
  logic [13:0] speed_q;
  logic        neg_q;

  logic        s_acc;
  assign s_tready = (state == S_IDLE) && !rst;
  assign s_acc    = s_tvalid && s_tready;

  // divider operand pick at accept
  logic        is_show;
  logic        need_div;
  logic [15:0] sel_val;
  logic        sel_neg;
  logic [15:0] sel_abs;
  logic [DIV_NW-1:0] in_num;
  logic [DIV_DW-1:0] in_den;

  assign is_show  = (in_sid == SID_SHOW);
  assign need_div = is_show && (in_prm == PID_LOAD || in_prm == PID_TEMP ||
                    in_prm == PID_THR || in_prm == PID_TREQ || in_prm == PID_TACT);

  always_comb begin
    unique case (in_prm)
      PID_TREQ: sel_val = in_treq;
      PID_TEMP: sel_val = in_temp;
      default:  sel_val = in_tact;
    endcase
    sel_neg = sel_val[15];
    sel_abs = sel_neg ? (16'h0000 - sel_val) : sel_val;
    unique case (in_prm)
      PID_LOAD: begin
        in_num = mul255(sel_abs);
        in_den = in_tav;
      end
      PID_TEMP: begin
        in_num = {8'h00, sel_abs};
        in_den = DIV_DW'(10);
      end
      PID_THR: begin
        in_num = in_thr[10] ? '0 : {13'b0, in_thr};
        in_den = DIV_DW'(10);
      end
      default: begin
        in_num = mul100(sel_abs);
        in_den = in_tav;
      end
    endcase
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  key_req_t key_req;
  key_rsp_t key_rsp;

  // throttle second pass: 255 * (thr/10) / 100
  always_comb begin
    if (state == S_DIV1) begin
      div_req.start = div_rsp.done && (prm_q == PID_THR);
      div_req.num   = mul255({9'b0, div_rsp.quo[6:0]});
      div_req.den   = DIV_DW'(100);
    end else begin
      div_req.start = s_acc && need_div;
      div_req.num   = in_num;
      div_req.den   = in_den;
    end
  end

  assign key_req.start = s_acc && (in_sid == SID_SEC) && (in_prm == SEC_KEY) && seed_fresh;
  assign key_req.seed  = seed_value;
  assign key_req.mult  = key_mul;
  assign key_req.mask  = key_xor;
  assign key_req.resp  = in_pay;

  dreq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dreq_key u_key (
    .clk (clk),
    .rst (rst),
    .req (key_req),
    .rsp (key_rsp)
  );

  logic key_ok_q;

  // reply build
  logic        fin_go;
  logic        has_reply;
  logic [2:0]  rlen;
  logic [7:0]  r0, r1, r2, r3, r4, r5;
  logic        set_seed, set_unlock, clr_fresh;
  logic [7:0]  tq_mag, tq_sgn, tq_byte;
  logic [12:0] temp_q;

  assign fin_go = (state == S_FIN) && (!m_tvalid || m_tready);
  assign tq_mag = div_rsp.quo[7:0];
  assign tq_sgn = neg_q ? (8'h00 - tq_mag) : tq_mag;
  assign tq_byte = (tav_q == '0) ? 8'h00 : tq_sgn;
  assign temp_q = div_rsp.quo[12:0];

  always_comb begin
    has_reply  = 1'b0;
    rlen       = 3'd0;
    r0 = 8'h00; r1 = 8'h00; r2 = 8'h00; r3 = 8'h00; r4 = 8'h00; r5 = 8'h00;
    set_seed   = 1'b0;
    set_unlock = 1'b0;
    clr_fresh  = 1'b0;
    if (sid_q == SID_SHOW) begin
      has_reply = 1'b1;
      r0 = SID_SHOW | RSP_OFS;
      r1 = prm_q;
      unique case (prm_q)
        PID_SUP00: begin rlen = 3'd6; r2 = 8'hD8; r3 = 8'h10; r4 = 8'h80; r5 = 8'h13; end
        PID_MON:   rlen = 3'd6;
        PID_LOAD:  begin rlen = 3'd3; r2 = tq_byte; end
        PID_TEMP: begin
          rlen = 3'd3;
          if (neg_q) begin
            r2 = (temp_q > 13'd40) ? 8'h00 : 8'(13'd40 - temp_q);
          end else begin
            r2 = (temp_q > 13'd215) ? 8'hFF : 8'(temp_q + 13'd40);
          end
        end
        PID_RPM:   begin rlen = 3'd4; r2 = speed_q[13:6]; r3 = {speed_q[5:0], 2'b00}; end
        PID_THR:   begin rlen = 3'd3; r2 = div_rsp.quo[7:0]; end
        PID_STD:   begin rlen = 3'd3; r2 = 8'h01; end
        PID_RUN:   rlen = 3'd4;
        PID_SUP20: begin rlen = 3'd6; r5 = 8'h01; end
        PID_DIST:  rlen = 3'd4;
        PID_FUEL:  rlen = 3'd3;
        PID_SUP40: begin rlen = 3'd6; r4 = 8'h80; r5 = 8'h01; end
        PID_FTYPE: begin rlen = 3'd3; r2 = 8'h08; end
        PID_SUP60: begin rlen = 3'd6; r2 = 8'hE0; end
        PID_TREQ, PID_TACT: begin rlen = 3'd3; r2 = tq_byte + 8'd125; end
        PID_TREF:  begin rlen = 3'd4; r2 = {1'b0, tav_q[14:8]}; r3 = tav_q[7:0]; end
        default:   has_reply = 1'b0;
      endcase
    end else if (sid_q == SID_SEC) begin
      r0 = SID_SEC | RSP_OFS;
      r1 = prm_q;
      if (prm_q == SEC_SEED) begin
        has_reply = 1'b1;
        rlen = 3'd6;
        if (!unlocked) begin
          set_seed = 1'b1;
          r2 = rnd_q[7:0]; r3 = rnd_q[15:8]; r4 = rnd_q[23:16]; r5 = rnd_q[31:24];
        end
      end else if (prm_q == SEC_KEY && seed_fresh) begin
        has_reply = 1'b1;
        if (key_ok_q) begin
          set_unlock = 1'b1;
          rlen = 3'd2;
        end else begin
          clr_fresh = 1'b1;
          rlen = 3'd3;
          r0 = RSP_NEG; r1 = SID_SEC; r2 = NRC_BAD_KEY;
        end
      end
    end else if (sid_q == SID_DL) begin
      // format byte is request byte 5, the top byte of the payload word
      if (prm_q == 8'h00 && pay_q[31:24] == DL_FMT && unlocked) begin
        has_reply = 1'b1;
        rlen = 3'd4;
        r0 = SID_DL | RSP_OFS; r1 = DL_LEN_FMT; r2 = 8'h01; r3 = 8'h02;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          if (need_div)             state_next = S_DIV1;
          else if (key_req.start)   state_next = S_KEY;
          else                      state_next = S_FIN;
        end
      end
      S_DIV1: if (div_rsp.done) state_next = (prm_q == PID_THR) ? S_DIV2 : S_FIN;
      S_DIV2: if (div_rsp.done) state_next = S_FIN;
      S_KEY:  if (key_rsp.done) state_next = S_FIN;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_mul    <= '0;
      key_xor    <= '0;
      unlocked   <= 1'b0;
      seed_fresh <= 1'b0;
      seed_value <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_MUL: key_mul <= cfg_wdata;
          REG_KEY_XOR: key_xor <= cfg_wdata;
          default: ;
        endcase
      end
      if (s_acc) begin
        sid_q   <= in_sid;
        prm_q   <= in_prm;
        pay_q   <= in_pay;
        rnd_q   <= in_rnd;
        tav_q   <= in_tav;
        speed_q <= in_speed;
        neg_q   <= sel_neg;
      end
      if (key_rsp.done) key_ok_q <= key_rsp.ok;
      if (fin_go) begin
        if (set_seed) begin
          seed_value <= rnd_q;
          seed_fresh <= 1'b1;
        end
        if (set_unlock) unlocked <= 1'b1;
        if (clr_fresh) seed_fresh <= 1'b0;
      end
      // a new reply may replace one taken in the same cycle
      if (fin_go && has_reply) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'b0, r5, r4, r3, r2, r1, r0, rlen};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### rtl/dreq_div.sv
module dreq_div
  import dreq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] den;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW+1:0] diff;
  logic              borrow;

  assign trial  = {rem, quo[DIV_NW-1]};
  assign diff   = {1'b0, trial} - {2'b00, den};
  assign borrow = diff[DIV_DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_NW);
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= borrow ? trial[DIV_DW-1:0] : diff[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], ~borrow};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### rtl/dreq_key.sv
module dreq_key
  import dreq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  key_req_t req,
  output key_rsp_t rsp
);

  // one key byte per cycle: (seed*mul ^ mask) low byte vs. response byte
  logic [31:0] seed;
  logic [31:0] mult;
  logic [31:0] mask;
  logic [31:0] resp;
  logic [1:0]  cnt;
  logic        busy;
  logic        done;
  logic        ok;
  logic [15:0] prod;
  logic        match;

  assign prod  = seed[7:0] * mult[7:0];
  assign match = ((prod[7:0] ^ mask[7:0]) == resp[31:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ok   <= 1'b1;
        seed <= req.seed;
        mult <= req.mult;
        mask <= req.mask;
        resp <= req.resp;
      end else if (busy) begin
        ok   <= ok & match;
        seed <= {8'h00, seed[31:8]};
        mult <= {8'h00, mult[31:8]};
        mask <= {8'h00, mask[31:8]};
        resp <= {resp[23:0], 8'h00};
        cnt  <= cnt + 2'd1;
        if (cnt == 2'(KEY_BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ok   = ok;

endmodule

### rtl/dreq_checker.sv
`include "diag_request_responder_defines.svh"

module dreq_checker
  import dreq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `DREQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `DREQ_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  `DREQ_ASSERT_IMP(a_len_range, m_tvalid, m_tdata[2:0] >= 3'd2 && m_tdata[2:0] <= 3'd6)
  `DREQ_ASSERT_IMP(a_head_byte, m_tvalid, m_tdata[10:3] == 8'h41 || m_tdata[10:3] == 8'h67 || m_tdata[10:3] == 8'h7F || m_tdata[10:3] == 8'h74)
  `DREQ_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

bind diag_request_responder dreq_checker u_dreq_checker (.*);
